@@ rtl/fppf_pkg.sv @@
// Shared types, constants and helpers for the force packet parse filter.
package fppf_pkg;

   localparam int PACKET_BYTES = 16;
   localparam int SUM_BYTES    = 14;
   localparam int IDX_W        = $clog2(PACKET_BYTES);
   localparam int SUM_W        = 12;   // 14 * 255 fits in 12 bits

   // Register indexes on the csr port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SENS_X   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SENS_Y   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SENS_Z   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_X = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_Y = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_OFFSET_Z = 3'd7;

   // Filter weight limits, Q0.16 (0.1 and 0.99)
   localparam logic [15:0] W_MIN   = 16'd6554;
   localparam logic [15:0] W_MAX   = 16'd64881;
   localparam logic [15:0] W_RESET = 16'd32768;
   localparam logic [23:0] SENS_RESET = 24'd1048576;

   // Shared multiplier operand widths
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 25;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int STEP_W  = 34;

   localparam int RSP_DATA_W = 128;
   localparam int RSP_USER_W = 1;

   localparam logic signed [63:0] S32_MAX_W = 64'sd2147483647;
   localparam logic signed [63:0] S32_MIN_W = -64'sd2147483648;

   typedef logic signed [31:0] force_type;

   function automatic force_type sat32(input logic signed [63:0] v);
      force_type r;
      if (v > S32_MAX_W) begin
         r = force_type'(S32_MAX_W[31:0]);
      end else if (v < S32_MIN_W) begin
         r = force_type'(S32_MIN_W[31:0]);
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/force_packet_parse_filter.sv @@
// Top level: sensor packet parser with checksum, scaling and exponential filter.
//
// Usage
//   req_*: one received sensor byte per beat (req_tdata = rx_byte). Bytes slide
//   through a 16-byte window. Once 16 bytes have arrived since reset or since the
//   last match and the window opens with the header_word bytes, the window is a
//   packet and one result beat follows on rsp_*.
//   rsp_tdata = {sensor_status, sample_count, force_z, force_y, force_x};
//   rsp_tuser = checksum_error (raw forces held, count/status repeat).
//   csr_*: plain write port, registers 0..7 in the order header, weight,
//   sens x/y/z, offset x/y/z. Write only while the block is idle.
// Sequencing
//   A byte that does not complete a packet leaves the sequencer idle. A matching
//   byte starts the sequencer: checksum accumulation over bytes 0..13, a check,
//   scaling per axis (skipped on checksum failure), offset and filter per axis,
//   then loading the output once the output register is free; req_tready stays
//   low throughout. Every product comes from the single shared multiplier.
// Reset and stall
//   Synchronous reset clears the window count, forces, filter state and
//   registers to their defaults. A result waits in the output register while
//   rsp_tready is low; bytes flow until the next result waits with req_tready low.
module force_packet_parse_filter (
   input  logic                             clock,
   input  logic                             reset,
   // input stream, tdata: rx_byte
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [7:0]                       req_tdata,
   // result stream, tdata: force_x, force_y, force_z, sample_count, sensor_status
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fppf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // tuser: checksum_error
   output logic [fppf_pkg::RSP_USER_W-1:0]  rsp_tuser,
   // configuration writes
   input  logic                             csr_we,
   input  logic [fppf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                      csr_wdata
);
   import fppf_pkg::*;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SUM   = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_SMUL  = 4'd3;
   localparam logic [3:0] S_SSAT  = 4'd4;
   localparam logic [3:0] S_XSUB  = 4'd5;
   localparam logic [3:0] S_DSUB  = 4'd6;
   localparam logic [3:0] S_FMUL  = 4'd7;
   localparam logic [3:0] S_FRND  = 4'd8;
   localparam logic [3:0] S_FUPD  = 4'd9;
   localparam logic [3:0] S_EMIT  = 4'd10;

   localparam logic [1:0] AXIS_LAST = 2'd2;
   localparam logic [IDX_W-1:0] SUM_LAST = IDX_W'(SUM_BYTES - 1);
   localparam logic [IDX_W:0]   FRESH_FULL = (IDX_W+1)'(PACKET_BYTES);

   // configuration
   logic [31:0]      header_ff, header_in;
   logic [15:0]      weight_ff, weight_in;
   logic [23:0]      sens_ff [3];
   logic [23:0]      sens_in [3];
   force_type        offset_ff [3];
   force_type        offset_in [3];

   // packet and filter state
   logic [7:0]       window_ff [PACKET_BYTES];
   logic [7:0]       window_in [PACKET_BYTES];
   logic [IDX_W:0]   fresh_ff, fresh_in;
   force_type        raw_ff [3];
   force_type        raw_in [3];
   force_type        filt_ff [3];
   force_type        filt_in [3];
   logic [15:0]      count_ff, count_in;
   logic [15:0]      status_ff, status_in;

   // sequencer and datapath
   logic [3:0]                state_ff, state_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic [1:0]                axis_ff, axis_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic                      err_ff, err_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   force_type                 x_ff, x_in;
   logic signed [MUL_A_W-1:0] d_ff, d_in;
   logic signed [STEP_W-1:0]  step_ff, step_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                      rsp_err_ff, rsp_err_in;

   // shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;

   logic                      req_beat;
   logic                      hdr_match;
   logic [IDX_W:0]            fresh_next;
   logic signed [15:0]        count_word;
   logic signed [PROD_W-1:0]  rnd;
   logic signed [PROD_W-1:0]  rnd_shift;
   logic signed [32:0]        xdiff;
   logic signed [PROD_W-1:0]  frnd;
   logic signed [STEP_W:0]    upd;
   logic [15:0]               w_clamp;

   assign req_tready = (state_ff == S_IDLE);
   assign req_beat   = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = RSP_USER_W'(rsp_err_ff);

   // header test looks at the window after the incoming byte shifts in
   assign hdr_match = (window_ff[1] == header_ff[31:24]) &&
                      (window_ff[2] == header_ff[23:16]) &&
                      (window_ff[3] == header_ff[15:8])  &&
                      (window_ff[4] == header_ff[7:0]);
   assign fresh_next = (fresh_ff < FRESH_FULL) ? fresh_ff + 1'b1 : fresh_ff;

   // axis counts live in bytes 8+2a (high) and 9+2a (low)
   assign count_word = {window_ff[{1'b1, axis_ff, 1'b0}], window_ff[{1'b1, axis_ff, 1'b1}]};

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_SMUL) begin
         mul_a = MUL_A_W'(count_word);
         mul_b = {1'b0, sens_ff[axis_ff]};
      end else begin
         mul_a = d_ff;
         mul_b = {(MUL_B_W-16)'(0), weight_ff};
      end
   end
   assign mul_p = mul_a * mul_b;

   // round half up, then drop four fraction bits (Q4.20 -> Q16.16)
   assign rnd       = prod_ff + PROD_W'(8);
   assign rnd_shift = rnd >>> 4;
   assign xdiff     = 33'(raw_ff[axis_ff]) - 33'(offset_ff[axis_ff]);
   assign frnd      = (prod_ff + PROD_W'(32768)) >>> 16;
   assign upd       = (STEP_W+1)'(filt_ff[axis_ff]) + (STEP_W+1)'(step_ff);

   always_comb begin
      if (csr_wdata[15:0] < W_MIN) begin
         w_clamp = W_MIN;
      end else if (csr_wdata[15:0] > W_MAX) begin
         w_clamp = W_MAX;
      end else begin
         w_clamp = csr_wdata[15:0];
      end
   end

   always_comb begin
      header_in = header_ff;
      weight_in = weight_ff;
      sens_in   = sens_ff;
      offset_in = offset_ff;
      window_in = window_ff;
      fresh_in  = fresh_ff;
      raw_in    = raw_ff;
      filt_in   = filt_ff;
      count_in  = count_ff;
      status_in = status_ff;
      state_in  = state_ff;
      idx_in    = idx_ff;
      axis_in   = axis_ff;
      sum_in    = sum_ff;
      err_in    = err_ff;
      prod_in   = prod_ff;
      x_in      = x_ff;
      d_in      = d_ff;
      step_in   = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_err_in   = rsp_err_ff;

      if (csr_we) begin
         unique case (csr_index)
            REG_HEADER:   header_in    = csr_wdata;
            REG_WEIGHT:   weight_in    = w_clamp;
            REG_SENS_X:   sens_in[0]   = csr_wdata[23:0];
            REG_SENS_Y:   sens_in[1]   = csr_wdata[23:0];
            REG_SENS_Z:   sens_in[2]   = csr_wdata[23:0];
            REG_OFFSET_X: offset_in[0] = csr_wdata;
            REG_OFFSET_Y: offset_in[1] = csr_wdata;
            REG_OFFSET_Z: offset_in[2] = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               for (int i = 0; i < PACKET_BYTES - 1; i++) begin
                  window_in[i] = window_ff[i+1];
               end
               window_in[PACKET_BYTES-1] = req_tdata;
               fresh_in = fresh_next;
               if (fresh_next == FRESH_FULL && hdr_match) begin
                  fresh_in = '0;
                  idx_in   = '0;
                  sum_in   = '0;
                  state_in = S_SUM;
               end
            end
         end
         S_SUM: begin
            sum_in = sum_ff + SUM_W'(window_ff[idx_ff]);
            idx_in = idx_ff + 1'b1;
            if (idx_ff == SUM_LAST) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            err_in  = {(16-SUM_W)'(0), sum_ff} != {window_ff[14], window_ff[15]};
            axis_in = '0;
            if (err_in) begin
               state_in = S_XSUB;
            end else begin
               count_in  = {window_ff[4], window_ff[5]};
               status_in = {window_ff[6], window_ff[7]};
               state_in  = S_SMUL;
            end
         end
         S_SMUL: begin
            prod_in  = mul_p;
            state_in = S_SSAT;
         end
         S_SSAT: begin
            raw_in[axis_ff] = sat32(64'(rnd_shift));
            if (axis_ff == AXIS_LAST) begin
               axis_in  = '0;
               state_in = S_XSUB;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_SMUL;
            end
         end
         S_XSUB: begin
            x_in     = sat32(64'(xdiff));
            state_in = S_DSUB;
         end
         S_DSUB: begin
            d_in     = 33'(x_ff) - 33'(filt_ff[axis_ff]);
            state_in = S_FMUL;
         end
         S_FMUL: begin
            prod_in  = mul_p;
            state_in = S_FRND;
         end
         S_FRND: begin
            step_in  = frnd[STEP_W-1:0];
            state_in = S_FUPD;
         end
         S_FUPD: begin
            filt_in[axis_ff] = sat32(64'(upd));
            if (axis_ff == AXIS_LAST) begin
               state_in = S_EMIT;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = S_XSUB;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {status_ff, count_ff, filt_ff[2], filt_ff[1], filt_ff[0]};
               rsp_err_in   = err_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff    <= '0;
         weight_ff    <= W_RESET;
         sens_ff      <= '{SENS_RESET, SENS_RESET, SENS_RESET};
         offset_ff    <= '{'0, '0, '0};
         fresh_ff     <= '0;
         raw_ff       <= '{'0, '0, '0};
         filt_ff      <= '{'0, '0, '0};
         count_ff     <= '0;
         status_ff    <= '0;
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         header_ff    <= header_in;
         weight_ff    <= weight_in;
         sens_ff      <= sens_in;
         offset_ff    <= offset_in;
         fresh_ff     <= fresh_in;
         raw_ff       <= raw_in;
         filt_ff      <= filt_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      window_ff   <= window_in;
      idx_ff      <= idx_in;
      axis_ff     <= axis_in;
      sum_ff      <= sum_in;
      err_ff      <= err_in;
      prod_ff     <= prod_in;
      x_ff        <= x_in;
      d_ff        <= d_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
      rsp_err_ff  <= rsp_err_in;
   end

endmodule

@@ rtl/fppf_checker.sv @@
// Port-level assertions for the force packet parse filter, bound to the top level.
module fppf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [fppf_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [fppf_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import fppf_pkg::*;

   // reset leaves no result pending and the byte side open
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("result or busy state survived reset");

   // a result only appears after the sequencer has been busy
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result beat without a computation");

   // no new byte is taken while a packet computation runs
   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (!req_tready && req_tvalid) |=> !$past(req_tvalid && req_tready))
      else $error("byte accepted while busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result beat changed");

endmodule

bind force_packet_parse_filter fppf_checker u_fppf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ tb/tb_force_packet_parse_filter.sv @@
// Self-checking testbench for the force packet parse filter: byte stream in, filtered forces out.
`timescale 1ns / 1ps

module tb_force_packet_parse_filter;
   import fppf_pkg::*;

   // ---------------------------------------------------------------- constants
   localparam int     NUM_PHASES     = 10;    // phase 0 is the post-reset zero packet
   localparam int     TRAFFIC_BYTES  = 130;   // random bytes per later phase
   localparam int     HOLD_PHASE     = 4;     // phase with the long receiver hold-off
   localparam int     HOLD_CYCLES    = 3000;
   localparam int     DRAIN_CYCLES   = 64;    // longer than a full sequencer pass
   localparam int     WATCHDOG_LIMIT = 20000; // quiet cycles; longer than the hold-off
   localparam longint S32_HI         = 64'sd2147483647;
   localparam longint S32_LO         = -64'sd2147483648;
   localparam logic [15:0] WGT_LO    = 16'd6554;   // 0.1 in Q0.16
   localparam logic [15:0] WGT_HI    = 16'd64881;  // 0.99 in Q0.16

   typedef struct packed {
      logic [2:0][31:0] force_v;       // x in [0]
      logic [15:0]      sample_count;
      logic [15:0]      sensor_status;
      logic             checksum_error;
   } force_result_type;

   // ---------------------------------------------------------------- DUT ports
   logic                    clock;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata  = 8'h00;    // rx_byte
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;   // force_x, force_y, force_z, sample_count, sensor_status
   logic [RSP_USER_W-1:0]   rsp_tuser;   // checksum_error
   logic                    csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [31:0]             csr_wdata  = '0;

   force_packet_parse_filter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------- tb state
   logic [7:0]       tx_bytes [$];          // bytes waiting for the driver
   force_result_type expected_results [$];  // predicted result beats, oldest first

   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   logic hold_req    = 1'b0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   int queued_total   = 0;
   int bytes_sent     = 0;
   int results_seen   = 0;
   int cksum_err_seen = 0;
   int mismatch_count = 0;

   string axis_name [3] = '{"force_x", "force_y", "force_z"};

   // Predictor copy of the registers
   logic [31:0] hdr_cfg  = 32'h0;
   logic [15:0] wgt_cfg  = 16'd32768;
   logic [23:0] sens_cfg [3] = '{default: 24'd1048576};
   longint      ofs_cfg  [3] = '{default: 0};

   // Predictor copy of the datapath state
   logic [7:0]  win [PACKET_BYTES] = '{default: 8'h00};   // [0] oldest
   int          fresh     = 0;
   longint      raw_f  [3] = '{default: 0};
   longint      filt_f [3] = '{default: 0};
   logic [15:0] last_cnt  = 16'h0;
   logic [15:0] last_stat = 16'h0;

   // ---------------------------------------------------------------- clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint clamp_s32(input longint v);
      if (v > S32_HI) return S32_HI;
      if (v < S32_LO) return S32_LO;
      return v;
   endfunction

   // Shift one byte into the window; on a header match predict the result beat.
   task automatic absorb_byte(input logic [7:0] rx);
      logic [15:0]        sum;
      logic signed [15:0] cnt;
      longint             prod;
      longint             x;
      longint             d;
      longint             stp;
      bit                 bad_sum;
      force_result_type   res;
      for (int i = 0; i < PACKET_BYTES - 1; i++) win[i] = win[i + 1];
      win[PACKET_BYTES - 1] = rx;
      if (fresh < PACKET_BYTES) fresh++;
      if (fresh < PACKET_BYTES) return;
      for (int i = 0; i < 4; i++) begin
         if (win[i] != hdr_cfg[31 - 8 * i -: 8]) return;
      end
      fresh = 0;   // next packet needs a full window of new bytes
      sum = 16'h0;
      for (int i = 0; i < SUM_BYTES; i++) sum += win[i];
      bad_sum = (sum != {win[14], win[15]});
      if (!bad_sum) begin
         last_cnt  = {win[4], win[5]};
         last_stat = {win[6], win[7]};
         for (int a = 0; a < 3; a++) begin
            cnt  = {win[8 + 2 * a], win[9 + 2 * a]};
            prod = longint'(cnt) * longint'(sens_cfg[a]);
            // Q4.20 * count -> Q16.16, round half up
            raw_f[a] = clamp_s32((prod + 8) >>> 4);
         end
      end
      // bad checksum: raw forces held, filter still steps toward them
      for (int a = 0; a < 3; a++) begin
         x   = clamp_s32(raw_f[a] - ofs_cfg[a]);
         d   = x - filt_f[a];
         stp = (longint'(wgt_cfg) * d + 32768) >>> 16;
         filt_f[a] = clamp_s32(filt_f[a] + stp);
         res.force_v[a] = 32'(filt_f[a]);
      end
      res.sample_count   = last_cnt;
      res.sensor_status  = last_stat;
      res.checksum_error = bad_sum;
      expected_results.push_back(res);
   endtask

   // ---------------------------------------------------------------- driver
   // Presents tx_bytes[0]; holds it while the block stalls.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            absorb_byte(req_tdata);
            void'(tx_bytes.pop_front());
            bytes_sent++;
         end
         if (req_tvalid && !req_tready) begin
            // beat not taken yet: keep it on the bus
         end else if (tx_bytes.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= tx_bytes[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- monitor
   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      force_result_type exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (rsp_tuser[0]) cksum_err_seen++;
            if (expected_results.size() == 0) begin
               $error("result beat with no prediction waiting");
               mismatch_count++;
            end else begin
               exp_r = expected_results.pop_front();
               for (int a = 0; a < 3; a++)
                  check_field(axis_name[a], exp_r.force_v[a], rsp_tdata[32 * a +: 32]);
               check_field("sample_count", 32'(exp_r.sample_count),
                           32'(rsp_tdata[111:96]));
               check_field("sensor_status", 32'(exp_r.sensor_status),
                           32'(rsp_tdata[127:112]));
               check_field("checksum_error", 32'(exp_r.checksum_error),
                           32'(rsp_tuser[0]));
            end
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // Long receiver hold-off: output register fills, sequencer blocks, req_tready drops.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_req) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               WATCHDOG_LIMIT, expected_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus helpers
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         REG_HEADER: begin
            hdr_cfg = val;
         end
         REG_WEIGHT: begin
            if (val[15:0] < WGT_LO)      wgt_cfg = WGT_LO;
            else if (val[15:0] > WGT_HI) wgt_cfg = WGT_HI;
            else                         wgt_cfg = val[15:0];
         end
         REG_SENS_X, REG_SENS_Y, REG_SENS_Z: begin
            sens_cfg[2'(idx - REG_SENS_X)] = val[23:0];
         end
         default: begin
            ofs_cfg[2'(idx - REG_OFFSET_X)] = $signed(val);
         end
      endcase
   endtask

   task automatic program_regs(input logic [31:0] hdr, input logic [31:0] wgt,
                               input logic [31:0] sx, input logic [31:0] sy,
                               input logic [31:0] sz, input logic [31:0] ox,
                               input logic [31:0] oy, input logic [31:0] oz);
      write_reg(REG_HEADER, hdr);
      write_reg(REG_WEIGHT, wgt);
      write_reg(REG_SENS_X, sx);
      write_reg(REG_SENS_Y, sy);
      write_reg(REG_SENS_Z, sz);
      write_reg(REG_OFFSET_X, ox);
      write_reg(REG_OFFSET_Y, oy);
      write_reg(REG_OFFSET_Z, oz);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic push_byte(input logic [7:0] b);
      tx_bytes.push_back(b);
      queued_total++;
   endtask

   // Builds a packet against the current header; len < 16 gives a cut-off packet.
   task automatic push_packet(input logic [15:0] cnt_v, input logic [15:0] stat_v,
                              input logic [15:0] cx, input logic [15:0] cy,
                              input logic [15:0] cz, input bit bad, input int len);
      logic [7:0]  pkt [PACKET_BYTES];
      logic [15:0] sum;
      for (int i = 0; i < 4; i++) pkt[i] = hdr_cfg[31 - 8 * i -: 8];
      {pkt[4], pkt[5]}   = cnt_v;
      {pkt[6], pkt[7]}   = stat_v;
      {pkt[8], pkt[9]}   = cx;
      {pkt[10], pkt[11]} = cy;
      {pkt[12], pkt[13]} = cz;
      sum = 16'h0;
      for (int i = 0; i < SUM_BYTES; i++) sum += pkt[i];
      if (bad) sum ^= 16'($urandom_range(1, 65535));
      {pkt[14], pkt[15]} = sum;
      for (int i = 0; i < len; i++) push_byte(pkt[i]);
   endtask

   // Axis counts lean on the signed 16-bit extremes.
   function automatic logic [15:0] rand_count();
      case ($urandom_range(0, 9))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] rand_offset();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return $urandom_range(0, 2097152) - 32'd1048576;   // about +-16 N
   endfunction

   // Mostly good packets; the rest bad checksums, cut-off packets and noise.
   task automatic add_traffic(input int n_bytes);
      int start;
      int pick;
      start = queued_total;
      while (queued_total - start < n_bytes) begin
         pick = $urandom_range(0, 99);
         if (pick < 72) begin
            push_packet(16'($urandom), 16'($urandom), rand_count(), rand_count(),
                        rand_count(), $urandom_range(0, 9) == 0, PACKET_BYTES);
         end else if (pick < 82) begin
            push_packet(16'($urandom), 16'($urandom), rand_count(), rand_count(),
                        rand_count(), 1'b0, $urandom_range(1, PACKET_BYTES - 1));
         end else if (pick < 92) begin
            repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
         end else begin
            push_packet(16'($urandom), 16'($urandom), rand_count(), rand_count(),
                        rand_count(), 1'b1, $urandom_range(4, 8));
         end
      end
   endtask

   task automatic set_idle(input int mode);
      case (mode)
         0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
         1: begin req_idle_pct = 45; rsp_stall_pct = 0;  end
         2: begin req_idle_pct = 0;  rsp_stall_pct = 45; end
         default: begin req_idle_pct = 27; rsp_stall_pct = 27; end
      endcase
   endtask

   // Idle = nothing queued, nothing on the bus, nothing predicted, sequencer drained.
   task automatic wait_idle();
      while (tx_bytes.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Phase 0: defaults, header 0; 16 zero bytes form a valid all-zero packet
      set_idle(0);
      repeat (PACKET_BYTES) push_byte(8'h00);
      wait_idle();

      for (int ph = 1; ph < NUM_PHASES; ph++) begin
         set_idle(ph % 4);
         case (ph)
            1: begin
               // weight below floor, max sensitivity, offset extremes
               program_regs(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_FFFF,
                            32'h00FF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
            end
            2: begin
               // weight above ceiling, zero and tiny sensitivity
               program_regs(32'h5AA5_C33C, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
                            32'h0010_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
            end
            default: begin
               program_regs($urandom, $urandom, $urandom, $urandom, $urandom,
                            rand_offset(), rand_offset(), rand_offset());
            end
         endcase
         if (ph == 1) begin
            // saturating scale, sign extremes, checksum failure holding raw forces,
            // a header seen before the window is full
            push_packet(16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h0000, 1'b0, PACKET_BYTES);
            push_packet(16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0, PACKET_BYTES);
            push_packet(16'h1234, 16'h5678, 16'h0001, 16'hFFFE, 16'h0100, 1'b1, PACKET_BYTES);
            push_packet(16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005, 1'b0, 6);
            push_packet(16'h00FF, 16'hFF00, 16'h0001, 16'hFFFE, 16'h1234, 1'b0, PACKET_BYTES);
         end
         if (ph == HOLD_PHASE) begin
            @(posedge clock);
            hold_req <= 1'b1;
            @(posedge clock);
            hold_req <= 1'b0;
         end
         add_traffic(TRAFFIC_BYTES);
         wait_idle();
      end

      $display("run: %0d bytes over %0d register settings, %0d results checked",
               bytes_sent, NUM_PHASES, results_seen);
      $display("     %0d with checksum error, %0d mismatches", cksum_err_seen,
               mismatch_count);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
